FILE: rtl/intel_hex_record_parser_unit_macros.svh
// Assertion macros for the parser RTL.
`ifndef INTEL_HEX_RECORD_PARSER_UNIT_MACROS_SVH
`define INTEL_HEX_RECORD_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, checked while the block is out of reset.
`define IHEX_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("Parser assertion failed.");

// Next-cycle implication, checked while the block is out of reset.
`define IHEX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("Parser assertion failed.");

`endif

FILE: rtl/ihex_pkg.sv
// Types and constants of the Intel HEX record parser.
package ihex_pkg;

    typedef enum logic [3:0] {
        PH_COLON   = 4'd0,
        PH_LEN     = 4'd1,
        PH_ADDR_HI = 4'd2,
        PH_ADDR_LO = 4'd3,
        PH_TYPE    = 4'd4,
        PH_DATA    = 4'd5,
        PH_EXT1    = 4'd6,
        PH_EXT2    = 4'd7,
        PH_CHECK   = 4'd8,
        PH_EOL     = 4'd9,
        PH_HALT    = 4'd10,
        PH_DONE    = 4'd11
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_REC  = 2'd1,
        KIND_EOF  = 2'd2,
        KIND_ERR  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_COLON = 3'd1,
        ERR_TYPE  = 3'd2,
        ERR_SUM   = 3'd3,
        ERR_DIGIT = 3'd4
    } err_t;

    localparam logic [7:0] REC_TYPE_DATA = 8'h00;
    localparam logic [7:0] REC_TYPE_EOF  = 8'h01;
    localparam logic [7:0] REC_TYPE_EXT  = 8'h04;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam logic [15:0] LINE_MAX = 16'hFFFF;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

endpackage

FILE: rtl/ihex_digit_decode.sv
// ASCII hex digit decoder for the Intel HEX record parser.
module ihex_digit_decode (
    input  logic [7:0]          char_in,
    output ihex_pkg::hex_digit_t digit
);
    import ihex_pkg::*;

    always_comb begin
        digit.valid = 1'b1;
        digit.value = 4'd0;
        if (char_in inside {[8'h30:8'h39]}) begin
            digit.value = char_in[3:0];
        end else if (char_in inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            digit.value = char_in[3:0] + 4'd9;
        end else begin
            digit.valid = 1'b0;
        end
    end

endmodule

FILE: rtl/intel_hex_record_parser_unit.sv
// Top level of the Intel HEX (INHX16) record parser: one character in, at most one result out.
//
// Channel | Ports                  | Contents
// --------+------------------------+------------------------------------------------------
// input   | s_tvalid/s_tready      | s_tdata[7:0] ascii_char
// result  | m_tvalid/m_tready      | m_tdata word_index, byte_offset, data_byte,
//         |                        | error_code, line_number; m_tuser kind
//
// Each request is decoded in the cycle it is accepted; its result appears in the result
// register on the next cycle, so one character per clock is sustained while m_tready is high.
// The result register is the only buffer: a new request is taken whenever it is empty or
// being drained in the same cycle.
// Reset is synchronous, active low, and returns the parser to waiting for a colon.
// After an error or an end-of-file record, requests are still consumed but give no result.
module intel_hex_record_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ascii_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [30:0] word_index, [38:31] byte_offset,
                                   // [46:39] data_byte, [49:47] error_code,
                                   // [65:50] line_number, [71:66] zero
    output logic [1:0]  m_tuser    // [1:0] kind
);
    import ihex_pkg::*;

    phase_t      phase_reg, phase_next;
    logic        digit_pending_reg, digit_pending_next;
    logic [3:0]  high_nibble_reg, high_nibble_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [7:0]  record_length_reg, record_length_next;
    logic [7:0]  address_high_reg, address_high_next;
    logic [14:0] record_word_addr_reg, record_word_addr_next;
    logic [7:0]  bytes_seen_reg, bytes_seen_next;
    logic [7:0]  ext_first_reg, ext_first_next;
    logic [30:0] ext_base_reg, ext_base_next;
    logic [15:0] line_counter_reg, line_counter_next;

    logic        out_valid_reg, out_valid_next;
    kind_t       out_kind_reg, out_kind_next;
    logic [30:0] out_word_index_reg, out_word_index_next;
    logic [7:0]  out_offset_reg, out_offset_next;
    logic [7:0]  out_data_reg, out_data_next;
    err_t        out_err_reg, out_err_next;
    logic [15:0] out_line_reg, out_line_next;

    logic        accept;
    logic        active;
    logic        byte_done;
    logic [7:0]  byte_value;
    logic [7:0]  sum_added;
    logic        emit;
    hex_digit_t  digit;

    ihex_digit_decode u_digit (
        .char_in (s_tdata),
        .digit   (digit)
    );

    assign s_tready   = !out_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign active     = accept && (s_tdata != CHAR_CR) &&
                        (phase_reg != PH_HALT) && (phase_reg != PH_DONE);
    assign byte_value = {high_nibble_reg, digit.value};
    assign sum_added  = running_sum_reg + byte_value;
    assign byte_done  = digit.valid && digit_pending_reg;

    // Next-state logic of the record phase and the parse context.
    always_comb begin
        phase_next            = phase_reg;
        digit_pending_next    = digit_pending_reg;
        high_nibble_next      = high_nibble_reg;
        running_sum_next      = running_sum_reg;
        record_length_next    = record_length_reg;
        address_high_next     = address_high_reg;
        record_word_addr_next = record_word_addr_reg;
        bytes_seen_next       = bytes_seen_reg;
        ext_first_next        = ext_first_reg;
        ext_base_next         = ext_base_reg;
        line_counter_next     = line_counter_reg;
        if (active) begin
            if (phase_reg == PH_COLON) begin
                if (s_tdata != CHAR_COLON) begin
                    phase_next = PH_HALT;
                end else begin
                    running_sum_next   = 8'd0;
                    digit_pending_next = 1'b0;
                    phase_next         = PH_LEN;
                end
            end else if (phase_reg == PH_EOL) begin
                if (line_counter_reg != LINE_MAX) begin
                    line_counter_next = line_counter_reg + 16'd1;
                end
                phase_next = PH_COLON;
            end else if (!digit.valid) begin
                phase_next = PH_HALT;
            end else if (!digit_pending_reg) begin
                high_nibble_next   = digit.value;
                digit_pending_next = 1'b1;
            end else begin
                digit_pending_next = 1'b0;
                running_sum_next   = sum_added;
                case (phase_reg)
                    PH_LEN: begin
                        record_length_next = byte_value;
                        phase_next         = PH_ADDR_HI;
                    end
                    PH_ADDR_HI: begin
                        address_high_next = byte_value;
                        phase_next        = PH_ADDR_LO;
                    end
                    PH_ADDR_LO: begin
                        record_word_addr_next = {address_high_reg, byte_value[7:1]};
                        phase_next            = PH_TYPE;
                    end
                    PH_TYPE: begin
                        if (byte_value == REC_TYPE_DATA) begin
                            bytes_seen_next = 8'd0;
                            phase_next = (record_length_reg != 8'd0) ? PH_DATA : PH_CHECK;
                        end else if (byte_value == REC_TYPE_EOF) begin
                            phase_next = PH_DONE;
                        end else if (byte_value == REC_TYPE_EXT) begin
                            phase_next = PH_EXT1;
                        end else begin
                            phase_next = PH_HALT;
                        end
                    end
                    PH_DATA: begin
                        bytes_seen_next = bytes_seen_reg + 8'd1;
                        if (bytes_seen_next == record_length_reg) begin
                            phase_next = PH_CHECK;
                        end
                    end
                    PH_EXT1: begin
                        ext_first_next = byte_value;
                        phase_next     = PH_EXT2;
                    end
                    PH_EXT2: begin
                        ext_base_next = {ext_first_reg, byte_value, 15'd0};
                        phase_next    = PH_CHECK;
                    end
                    PH_CHECK: begin
                        phase_next = (sum_added != 8'd0) ? PH_HALT : PH_EOL;
                    end
                    default: begin
                        phase_next = PH_HALT;
                    end
                endcase
            end
        end
    end

    // Result selection for the accepted request.
    always_comb begin
        emit                = 1'b0;
        out_kind_next       = KIND_DATA;
        out_word_index_next = 31'd0;
        out_offset_next     = 8'd0;
        out_data_next       = 8'd0;
        out_err_next        = ERR_NONE;
        out_line_next       = line_counter_reg;
        if (active) begin
            if (phase_reg == PH_COLON) begin
                if (s_tdata != CHAR_COLON) begin
                    emit          = 1'b1;
                    out_kind_next = KIND_ERR;
                    out_err_next  = ERR_COLON;
                end
            end else if (phase_reg == PH_EOL) begin
                emit = 1'b0;
            end else if (!digit.valid) begin
                emit          = 1'b1;
                out_kind_next = KIND_ERR;
                out_err_next  = ERR_DIGIT;
            end else if (byte_done) begin
                case (phase_reg)
                    PH_TYPE: begin
                        if (byte_value == REC_TYPE_EOF) begin
                            emit          = 1'b1;
                            out_kind_next = KIND_EOF;
                        end else if (byte_value != REC_TYPE_DATA &&
                                     byte_value != REC_TYPE_EXT) begin
                            emit          = 1'b1;
                            out_kind_next = KIND_ERR;
                            out_err_next  = ERR_TYPE;
                        end
                    end
                    PH_DATA: begin
                        emit                = 1'b1;
                        out_kind_next       = KIND_DATA;
                        out_word_index_next = {16'd0, record_word_addr_reg} | ext_base_reg;
                        out_offset_next     = bytes_seen_reg;
                        out_data_next       = byte_value;
                    end
                    PH_CHECK: begin
                        emit = 1'b1;
                        if (sum_added != 8'd0) begin
                            out_kind_next = KIND_ERR;
                            out_err_next  = ERR_SUM;
                        end else begin
                            out_kind_next = KIND_REC;
                        end
                    end
                    default: begin
                        emit = 1'b0;
                    end
                endcase
            end
        end
    end

    always_comb begin
        if (accept) begin
            out_valid_next = emit;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg            <= PH_COLON;
            digit_pending_reg    <= 1'b0;
            high_nibble_reg      <= 4'd0;
            running_sum_reg      <= 8'd0;
            record_length_reg    <= 8'd0;
            address_high_reg     <= 8'd0;
            record_word_addr_reg <= 15'd0;
            bytes_seen_reg       <= 8'd0;
            ext_first_reg        <= 8'd0;
            ext_base_reg         <= 31'd0;
            line_counter_reg     <= 16'd1;
            out_valid_reg        <= 1'b0;
        end else begin
            phase_reg            <= phase_next;
            digit_pending_reg    <= digit_pending_next;
            high_nibble_reg      <= high_nibble_next;
            running_sum_reg      <= running_sum_next;
            record_length_reg    <= record_length_next;
            address_high_reg     <= address_high_next;
            record_word_addr_reg <= record_word_addr_next;
            bytes_seen_reg       <= bytes_seen_next;
            ext_first_reg        <= ext_first_next;
            ext_base_reg         <= ext_base_next;
            line_counter_reg     <= line_counter_next;
            out_valid_reg        <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_kind_reg       <= out_kind_next;
            out_word_index_reg <= out_word_index_next;
            out_offset_reg     <= out_offset_next;
            out_data_reg       <= out_data_next;
            out_err_reg        <= out_err_next;
            out_line_reg       <= out_line_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {6'd0, out_line_reg, out_err_reg, out_data_reg,
                       out_offset_reg, out_word_index_reg};

`include "intel_hex_record_parser_unit_macros.svh"

    `IHEX_ASSERT_NEXT(a_halt_sticky, phase_reg == PH_HALT, phase_reg == PH_HALT)
    `IHEX_ASSERT_NEXT(a_error_halts, accept && emit && out_kind_next == KIND_ERR,
        phase_reg == PH_HALT)
    `IHEX_ASSERT_IMP(a_line_nonzero, 1'b1, line_counter_reg != 16'd0)
    `IHEX_ASSERT_IMP(a_pending_in_record, digit_pending_reg,
        phase_reg == PH_LEN || phase_reg == PH_ADDR_HI || phase_reg == PH_ADDR_LO ||
        phase_reg == PH_TYPE || phase_reg == PH_DATA || phase_reg == PH_EXT1 ||
        phase_reg == PH_EXT2 || phase_reg == PH_CHECK || phase_reg == PH_HALT)

endmodule

FILE: sim/intel_hex_record_parser_unit_checker.sv
`timescale 1ns / 1ps
// Checker for the Intel HEX record parser: predicts every result from the accepted characters.
module intel_hex_record_parser_unit_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          mismatch_count,
    output int          results_due
);
    import ihex_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [30:0] word_index;
        logic [7:0]  byte_offset;
        logic [7:0]  data_byte;
        logic [2:0]  error_code;
        logic [15:0] line_number;
    } parse_result_t;

    parse_result_t results_queue[$];
    parse_result_t oldest;

    phase_t      phase;
    logic        digit_pending;
    logic [3:0]  high_nibble;
    logic [7:0]  running_sum;
    logic [7:0]  record_len;
    logic [7:0]  addr_high;
    logic [14:0] record_word_addr;
    logic [7:0]  bytes_seen;
    logic [7:0]  ext_first_byte;
    logic [30:0] ext_word_base;
    logic [15:0] line_count;

    task automatic reset_parser();
        phase = PH_COLON;
        digit_pending = 1'b0;
        high_nibble = '0;
        running_sum = '0;
        record_len = '0;
        addr_high = '0;
        record_word_addr = '0;
        bytes_seen = '0;
        ext_first_byte = '0;
        ext_word_base = '0;
        line_count = 16'd1;
    endtask

    task automatic expect_result(input kind_t kind, input logic [30:0] widx,
                                 input logic [7:0] offset, input logic [7:0] data,
                                 input err_t code);
        parse_result_t r;
        r.kind = kind;
        r.word_index = widx;
        r.byte_offset = offset;
        r.data_byte = data;
        r.error_code = code;
        r.line_number = line_count;
        results_queue.push_back(r);
    endtask

    task automatic halt_parser(input err_t code);
        phase = PH_HALT;
        expect_result(KIND_ERR, '0, '0, '0, code);
    endtask

    task automatic parse_char(input logic [7:0] c);
        hex_digit_t  digit;
        logic [7:0]  b;
        logic [31:0] base;
        digit.valid = 1'b1;
        digit.value = c[3:0];
        if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            digit.value = c[3:0] + 4'd9;
        end else if (!(c >= 8'h30 && c <= 8'h39)) begin
            digit.valid = 1'b0;
        end
        if (c != CHAR_CR) begin
            case (phase)
                PH_HALT, PH_DONE: ;
                PH_COLON: begin
                    if (c == CHAR_COLON) begin
                        running_sum = '0;
                        digit_pending = 1'b0;
                        phase = PH_LEN;
                    end else begin
                        halt_parser(ERR_COLON);
                    end
                end
                PH_EOL: begin
                    if (line_count != LINE_MAX) line_count = line_count + 16'd1;
                    phase = PH_COLON;
                end
                default: begin
                    if (!digit.valid) begin
                        halt_parser(ERR_DIGIT);
                    end else if (!digit_pending) begin
                        high_nibble = digit.value;
                        digit_pending = 1'b1;
                    end else begin
                        digit_pending = 1'b0;
                        b = {high_nibble, digit.value};
                        running_sum = running_sum + b;
                        case (phase)
                            PH_LEN: begin
                                record_len = b;
                                phase = PH_ADDR_HI;
                            end
                            PH_ADDR_HI: begin
                                addr_high = b;
                                phase = PH_ADDR_LO;
                            end
                            PH_ADDR_LO: begin
                                record_word_addr = {addr_high, b[7:1]};
                                phase = PH_TYPE;
                            end
                            PH_TYPE: begin
                                if (b == REC_TYPE_DATA) begin
                                    bytes_seen = '0;
                                    phase = (record_len != 8'd0) ? PH_DATA : PH_CHECK;
                                end else if (b == REC_TYPE_EOF) begin
                                    phase = PH_DONE;
                                    expect_result(KIND_EOF, '0, '0, '0, ERR_NONE);
                                end else if (b == REC_TYPE_EXT) begin
                                    phase = PH_EXT1;
                                end else begin
                                    halt_parser(ERR_TYPE);
                                end
                            end
                            PH_DATA: begin
                                expect_result(KIND_DATA, {16'd0, record_word_addr} | ext_word_base,
                                              bytes_seen, b, ERR_NONE);
                                bytes_seen = bytes_seen + 8'd1;
                                if (bytes_seen == record_len) phase = PH_CHECK;
                            end
                            PH_EXT1: begin
                                ext_first_byte = b;
                                phase = PH_EXT2;
                            end
                            PH_EXT2: begin
                                base = ({24'd0, ext_first_byte} << 23) | ({24'd0, b} << 15);
                                ext_word_base = base[30:0];
                                phase = PH_CHECK;
                            end
                            PH_CHECK: begin
                                if (running_sum != 8'd0) begin
                                    halt_parser(ERR_SUM);
                                end else begin
                                    phase = PH_EOL;
                                    expect_result(KIND_REC, '0, '0, '0, ERR_NONE);
                                end
                            end
                            default: phase = PH_HALT;
                        endcase
                    end
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_parser();
            results_queue.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (results_queue.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual kind %0d",
                             $time, m_tuser);
                    mismatch_count++;
                end else begin
                    oldest = results_queue.pop_front();
                    check_field("kind", 32'(oldest.kind), 32'(m_tuser));
                    check_field("word_index", 32'(oldest.word_index), 32'(m_tdata[30:0]));
                    check_field("byte_offset", 32'(oldest.byte_offset), 32'(m_tdata[38:31]));
                    check_field("data_byte", 32'(oldest.data_byte), 32'(m_tdata[46:39]));
                    check_field("error_code", 32'(oldest.error_code), 32'(m_tdata[49:47]));
                    check_field("line_number", 32'(oldest.line_number), 32'(m_tdata[65:50]));
                end
            end
            if (s_tvalid && s_tready) parse_char(s_tdata);
        end
        results_due = results_queue.size();
    end

endmodule

FILE: sim/intel_hex_record_parser_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the Intel HEX record parser: clock, reset, character stimulus and verdict.
module intel_hex_record_parser_unit_tb;
    import ihex_pkg::*;

    localparam int STALL_LIMIT        = 2000;
    localparam int HOLD_CYCLES        = 300;
    localparam int RANDOM_CHARS       = 1350;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam int END_EOF       = 0;
    localparam int END_NO_COLON  = 1;
    localparam int END_BAD_TYPE  = 2;
    localparam int END_BAD_SUM   = 3;
    localparam int END_BAD_DIGIT = 4;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;

    int   mismatch_count;
    int   results_due;
    int   chars_sent = 0;
    int   cr_pct = 0;
    bit   src_gaps = 1'b0;
    bit   sink_gaps = 1'b0;
    bit   hold_request = 1'b0;
    logic [7:0] rec_bytes[$];
    logic [7:0] line_chars[$];

    always #10 aclk = ~aclk;

    intel_hex_record_parser_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    intel_hex_record_parser_unit_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 8'h00;
        if (r < 20) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] rand_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'h0000;
        if (r < 20) return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 16);
        if (r < 95) return $urandom_range(17, 40);
        return $urandom_range(41, 255);
    endfunction

    function automatic logic [7:0] any_char_except(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == a || c == b) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == CHAR_CR || (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46)
               || (c >= 8'h61 && c <= 8'h66)) begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + n;
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    function automatic logic [7:0] pick_eol();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return CHAR_LF;
        if (r < 85) return CHAR_COLON;
        return any_char_except(CHAR_CR, CHAR_CR);
    endfunction

    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = src_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        chars_sent++;
        @(negedge aclk);
    endtask

    task automatic send_line();
        foreach (line_chars[i]) begin
            if ($urandom_range(0, 99) < cr_pct) send_char(CHAR_CR);
            send_char(line_chars[i]);
        end
    endtask

    task automatic start_record(input logic [7:0] len, input logic [15:0] addr,
                                input logic [7:0] rtype);
        rec_bytes.delete();
        rec_bytes.push_back(len);
        rec_bytes.push_back(addr[15:8]);
        rec_bytes.push_back(addr[7:0]);
        rec_bytes.push_back(rtype);
    endtask

    task automatic build_line(input logic [7:0] sum_delta, input logic [7:0] eol_char);
        logic [7:0] sum;
        sum = 8'd0;
        foreach (rec_bytes[i]) sum = sum + rec_bytes[i];
        rec_bytes.push_back(8'd0 - sum + sum_delta);
        line_chars.delete();
        line_chars.push_back(CHAR_COLON);
        foreach (rec_bytes[i]) begin
            line_chars.push_back(hex_char(rec_bytes[i][7:4]));
            line_chars.push_back(hex_char(rec_bytes[i][3:0]));
        end
        line_chars.push_back(eol_char);
    endtask

    task automatic data_record(input int len, input logic [15:0] addr,
                               input logic [7:0] eol_char);
        start_record(8'(len), addr, REC_TYPE_DATA);
        repeat (len) rec_bytes.push_back(rand_byte());
        build_line(8'd0, eol_char);
        send_line();
    endtask

    task automatic ext_record(input logic [7:0] len, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] eol_char);
        start_record(len, rand_addr(), REC_TYPE_EXT);
        rec_bytes.push_back(b1);
        rec_bytes.push_back(b2);
        build_line(8'd0, eol_char);
        send_line();
    endtask

    task automatic random_record();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) data_record(pick_len(), rand_addr(), pick_eol());
        else if (r < 72) data_record(0, rand_addr(), pick_eol());
        else if (r < 90) ext_record(rand_byte(), rand_byte(), rand_byte(), pick_eol());
        else ext_record(rand_byte(), 8'h00, 8'h00, pick_eol());
    endtask

    initial begin : sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (sink_gaps) stall_left = pick_gap();
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        @(posedge aresetn);
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int         ending;
        int         idx;
        bit         hold_done;
        logic [7:0] rtype;
        hold_done = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed records: extreme bases, addresses and bytes, odd line ends, carriage returns.
        ext_record(8'h00, 8'hFF, 8'hFF, CHAR_LF);
        start_record(8'h02, 16'hFFFF, REC_TYPE_DATA);
        rec_bytes.push_back(8'h00);
        rec_bytes.push_back(8'hFF);
        build_line(8'd0, CHAR_COLON);
        send_line();
        cr_pct = 100;
        data_record(0, 16'h0001, CHAR_LF);
        cr_pct = 0;
        ext_record(8'h02, 8'h00, 8'h00, 8'hFF);
        data_record(1, 16'h0000, CHAR_LF);

        while (chars_sent < RANDOM_CHARS) begin
            src_gaps = ($urandom_range(0, 3) != 0);
            sink_gaps = ($urandom_range(0, 3) != 0);
            cr_pct = $urandom_range(0, 1) ? 0 : 5;
            if (!hold_done && chars_sent > 400) begin
                // The receiver stalls while characters keep coming, so the parser backs up.
                hold_done = 1'b1;
                hold_request = 1'b1;
                src_gaps = 1'b0;
                data_record(16, rand_addr(), CHAR_LF);
            end
            repeat (8) random_record();
        end

        src_gaps = 1'b1;
        sink_gaps = 1'b1;
        cr_pct = 5;
        repeat (3) random_record();

        ending = $urandom_range(END_EOF, END_BAD_DIGIT);
        case (ending)
            END_EOF: begin
                start_record(rand_byte(), rand_addr(), REC_TYPE_EOF);
                build_line(8'($urandom_range(0, 255)), CHAR_LF);
                send_line();
            end
            END_NO_COLON: begin
                send_char(any_char_except(CHAR_COLON, CHAR_CR));
            end
            END_BAD_TYPE: begin
                rtype = 8'($urandom_range(0, 255));
                while (rtype == REC_TYPE_DATA || rtype == REC_TYPE_EOF || rtype == REC_TYPE_EXT) begin
                    rtype = 8'($urandom_range(0, 255));
                end
                start_record(8'h02, rand_addr(), rtype);
                rec_bytes.push_back(rand_byte());
                rec_bytes.push_back(rand_byte());
                build_line(8'd0, CHAR_LF);
                send_line();
            end
            END_BAD_SUM: begin
                start_record(8'h02, rand_addr(), REC_TYPE_DATA);
                rec_bytes.push_back(rand_byte());
                rec_bytes.push_back(rand_byte());
                build_line(8'($urandom_range(1, 255)), CHAR_LF);
                send_line();
            end
            default: begin
                start_record(8'h03, rand_addr(), REC_TYPE_DATA);
                repeat (3) rec_bytes.push_back(rand_byte());
                build_line(8'd0, CHAR_LF);
                idx = $urandom_range(1, line_chars.size() - 2);
                line_chars[idx] = non_hex_char();
                send_line();
            end
        endcase

        // Everything after the parser has stopped must be swallowed without a result.
        repeat (30) send_char(8'($urandom_range(0, 255)));
        data_record(2, rand_addr(), CHAR_LF);
        s_tvalid <= 1'b0;

        while (results_due != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
